// ===== rtl/l4hpf_pkg.sv =====
// ----------------------------------------------------------------------------
// l4hpf_pkg
// Shared types, codes and lookup functions of the layer four header filter.
// ----------------------------------------------------------------------------
package l4hpf_pkg;

  localparam int FILTER_ENTRIES_DEF = 4;

  // ip protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // verdict codes
  localparam logic [2:0] VERDICT_NONE    = 3'd0;
  localparam logic [2:0] VERDICT_FORWARD = 3'd1;
  localparam logic [2:0] VERDICT_DROP    = 3'd2;
  localparam logic [2:0] VERDICT_DECODED = 3'd3;
  localparam logic [2:0] VERDICT_UNKNOWN = 3'd4;

  // message kinds
  localparam logic [3:0] KIND_NONE       = 4'd0;
  localparam logic [3:0] KIND_IGMP_QUERY = 4'd1;
  localparam logic [3:0] KIND_IGMP_REP   = 4'd2;
  localparam logic [3:0] KIND_IGMP_NREP  = 4'd3;
  localparam logic [3:0] KIND_IGMP_LEAVE = 4'd4;
  localparam logic [3:0] KIND_IGMP_DVMRP = 4'd5;
  localparam logic [3:0] KIND_IGMP_PIM   = 4'd6;
  localparam logic [3:0] KIND_IGMP_MRESP = 4'd7;
  localparam logic [3:0] KIND_IGMP_MTRC  = 4'd8;
  localparam logic [3:0] KIND_ECHO_REPLY = 4'd9;
  localparam logic [3:0] KIND_ECHO_REQ   = 4'd10;
  localparam logic [3:0] KIND_TS_REQ     = 4'd11;
  localparam logic [3:0] KIND_TS_REPLY   = 4'd12;

  // igmp type bytes
  localparam logic [7:0] IGMP_QUERY = 8'h11;
  localparam logic [7:0] IGMP_REP   = 8'h12;
  localparam logic [7:0] IGMP_NREP  = 8'h16;
  localparam logic [7:0] IGMP_LEAVE = 8'h17;
  localparam logic [7:0] IGMP_DVMRP = 8'h13;
  localparam logic [7:0] IGMP_PIM   = 8'h14;
  localparam logic [7:0] IGMP_MRESP = 8'h1e;
  localparam logic [7:0] IGMP_MTRC  = 8'h1f;

  // icmp type bytes
  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] ICMP_TS_REQ     = 8'd13;
  localparam logic [7:0] ICMP_TS_REPLY   = 8'd14;

  localparam logic [7:0] OFFSET_MASK = 8'hf0;
  localparam logic [5:0] UDP_HDR_LEN = 6'd8;

  // register indexes
  localparam logic [2:0] REG_ENABLES   = 3'd0;
  localparam logic [2:0] REG_TCP_COUNT = 3'd1;
  localparam logic [2:0] REG_UDP_COUNT = 3'd2;
  localparam logic [2:0] REG_TCP_FIRST = 3'd3;
  localparam logic [2:0] REG_TCP_SEC   = 3'd4;
  localparam logic [2:0] REG_UDP_FIRST = 3'd5;
  localparam logic [2:0] REG_UDP_SEC   = 3'd6;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  typedef struct packed {
    logic [3:0]   enables;
    logic [2:0]   tcp_count;
    logic [2:0]   udp_count;
    logic [127:0] tcp_tab;   // entry k in bits 32k+31..32k
    logic [127:0] udp_tab;
  } cfg_t;

  typedef struct packed {
    logic [15:0] segment_length;
    logic [7:0]  offset_byte;
    logic [31:0] header_word;
    logic [7:0]  protocol;
  } in_t;

  typedef struct packed {
    logic [3:0]  message_kind;
    logic [15:0] payload_length;
    logic [5:0]  payload_offset;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [2:0]  verdict;
  } res_t;

  function automatic logic [3:0] igmp_kind(input logic [7:0] t);
    logic [3:0] k;
    unique case (t)
      IGMP_QUERY: k = KIND_IGMP_QUERY;
      IGMP_REP:   k = KIND_IGMP_REP;
      IGMP_NREP:  k = KIND_IGMP_NREP;
      IGMP_LEAVE: k = KIND_IGMP_LEAVE;
      IGMP_DVMRP: k = KIND_IGMP_DVMRP;
      IGMP_PIM:   k = KIND_IGMP_PIM;
      IGMP_MRESP: k = KIND_IGMP_MRESP;
      IGMP_MTRC:  k = KIND_IGMP_MTRC;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] icmp_kind(input logic [7:0] t);
    logic [3:0] k;
    unique case (t)
      ICMP_ECHO_REPLY: k = KIND_ECHO_REPLY;
      ICMP_ECHO_REQ:   k = KIND_ECHO_REQ;
      ICMP_TS_REQ:     k = KIND_TS_REQ;
      ICMP_TS_REPLY:   k = KIND_TS_REPLY;
      default:         k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/l4hpf_regs.sv =====
// ----------------------------------------------------------------------------
// l4hpf_regs
// Configuration register file behind the apb port, 64-bit registers at 8*i.
// ----------------------------------------------------------------------------
module l4hpf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [l4hpf_pkg::ADDR_W-1:0] paddr,
  input  logic [l4hpf_pkg::DATA_W-1:0] pwdata,
  output logic [l4hpf_pkg::DATA_W-1:0] prdata,
  output l4hpf_pkg::cfg_t             cfg
);
  import l4hpf_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[5:3];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enables   <= 4'hf;
      cfg.tcp_count <= 3'd0;
      cfg.udp_count <= 3'd0;
      cfg.tcp_tab   <= '0;
      cfg.udp_tab   <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ENABLES:   cfg.enables          <= pwdata[3:0];
        REG_TCP_COUNT: cfg.tcp_count        <= pwdata[2:0];
        REG_UDP_COUNT: cfg.udp_count        <= pwdata[2:0];
        REG_TCP_FIRST: cfg.tcp_tab[63:0]    <= pwdata;
        REG_TCP_SEC:   cfg.tcp_tab[127:64]  <= pwdata;
        REG_UDP_FIRST: cfg.udp_tab[63:0]    <= pwdata;
        REG_UDP_SEC:   cfg.udp_tab[127:64]  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLES:   prdata = {60'd0, cfg.enables};
      REG_TCP_COUNT: prdata = {61'd0, cfg.tcp_count};
      REG_UDP_COUNT: prdata = {61'd0, cfg.udp_count};
      REG_TCP_FIRST: prdata = cfg.tcp_tab[63:0];
      REG_TCP_SEC:   prdata = cfg.tcp_tab[127:64];
      REG_UDP_FIRST: prdata = cfg.udp_tab[63:0];
      REG_UDP_SEC:   prdata = cfg.udp_tab[127:64];
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/l4hpf_class.sv =====
// ----------------------------------------------------------------------------
// l4hpf_class
// Classifier logic: port filter match, payload offset and length, type decode.
// ----------------------------------------------------------------------------
module l4hpf_class #(
  parameter int FILTER_ENTRIES = l4hpf_pkg::FILTER_ENTRIES_DEF
) (
  input  l4hpf_pkg::in_t  item,
  input  l4hpf_pkg::cfg_t cfg,
  output l4hpf_pkg::res_t res
);
  import l4hpf_pkg::*;

  localparam logic [2:0] ENTRIES = 3'(FILTER_ENTRIES);

  logic                      is_tcp;
  logic                      is_udp;
  logic [15:0]               sp;
  logic [15:0]               dp;
  logic [7:0]                type_byte;
  logic [2:0]                count;
  logic [2:0]                n;
  logic [127:0]              tab;
  logic [FILTER_ENTRIES-1:0] hit;
  logic                      pass;
  logic [7:0]                tcp_hdr;
  logic [5:0]                poff;
  logic [15:0]               poff_w;
  logic [3:0]                igmp_k;
  logic [3:0]                icmp_k;

  assign is_tcp    = (item.protocol == PROTO_TCP);
  assign is_udp    = (item.protocol == PROTO_UDP);
  assign sp        = item.header_word[31:16];
  assign dp        = item.header_word[15:0];
  assign type_byte = item.header_word[31:24];
  assign count     = is_tcp ? cfg.tcp_count : cfg.udp_count;
  assign tab       = is_tcp ? cfg.tcp_tab : cfg.udp_tab;
  assign n         = (count > ENTRIES) ? ENTRIES : count;

  // zero port in an entry is a wildcard
  always_comb begin
    for (int k = 0; k < FILTER_ENTRIES; k++) begin
      hit[k] = (3'(k) < n)
             && ((tab[32*k+16 +: 16] == 16'd0) || (tab[32*k+16 +: 16] == sp))
             && ((tab[32*k +: 16] == 16'd0) || (tab[32*k +: 16] == dp));
    end
  end

  // data offset nibble in words, times four gives bytes
  assign tcp_hdr = (item.offset_byte & OFFSET_MASK) >> 2;

  assign pass   = (n == 3'd0) || (|hit);
  assign poff   = is_tcp ? tcp_hdr[5:0] : UDP_HDR_LEN;
  assign poff_w = {10'd0, poff};
  assign igmp_k = igmp_kind(type_byte);
  assign icmp_k = icmp_kind(type_byte);

  always_comb begin
    res = '0;
    if (is_tcp || is_udp) begin
      if ((is_tcp && cfg.enables[0]) || (is_udp && cfg.enables[1])) begin
        res.source_port = sp;
        res.dest_port   = dp;
        if (pass) begin
          res.verdict        = VERDICT_FORWARD;
          res.payload_offset = poff;
          res.payload_length = (item.segment_length > poff_w)
                             ? item.segment_length - poff_w : 16'd0;
        end else begin
          res.verdict = VERDICT_DROP;
        end
      end
    end else if (item.protocol == PROTO_IGMP) begin
      if (cfg.enables[2]) begin
        res.message_kind = igmp_k;
        res.verdict      = (igmp_k != KIND_NONE) ? VERDICT_DECODED : VERDICT_UNKNOWN;
      end
    end else if (item.protocol == PROTO_ICMP) begin
      if (cfg.enables[3]) begin
        res.message_kind = icmp_k;
        res.verdict      = (icmp_k != KIND_NONE) ? VERDICT_DECODED : VERDICT_NONE;
      end
    end else begin
      res.verdict = VERDICT_UNKNOWN;
    end
  end

endmodule

// ===== rtl/l4_header_port_filter.sv =====
// ----------------------------------------------------------------------------
// l4_header_port_filter
// Layer four header classifier with per-protocol port filter tables.
// ----------------------------------------------------------------------------
//   channel   dir   width  contents
//   s_axis    in    64     protocol, header_word, offset_byte, segment_length
//   m_axis    out   64     verdict, ports, payload offset/length, message kind
//   apb       in    64     seven 64-bit registers at byte address 8*i
//
// one word per cycle sustained while m_tready stays high; a result word is
// presented once its input word has passed the input register, the classifier
// and the result register.
// rst clears both valid flags and loads the register reset values.
// a stall on m_tready holds the result register and backs up into the input
// register; s_tready drops only when both stages hold a word.
// ----------------------------------------------------------------------------
module l4_header_port_filter #(
  parameter int FILTER_ENTRIES = l4hpf_pkg::FILTER_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // protocol[7:0], header_word[39:8], offset_byte[47:40], segment_length[63:48]
  input  logic [63:0]                 s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // verdict[2:0], source_port[18:3], dest_port[34:19], payload_offset[40:35],
  // payload_length[56:41], message_kind[60:57], zero[63:61]
  output logic [63:0]                 m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [l4hpf_pkg::ADDR_W-1:0] paddr,
  input  logic [l4hpf_pkg::DATA_W-1:0] pwdata,
  output logic [l4hpf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import l4hpf_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  res_t res_d;
  res_t res_q;
  logic in_valid;
  logic out_valid;
  logic adv;

  assign pready = 1'b1;

  l4hpf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  l4hpf_class #(
    .FILTER_ENTRIES (FILTER_ENTRIES)
  ) u_class (
    .item (in_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  // input stage moves forward when the result register is free or draining
  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_q <= in_t'(s_tdata);
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, res_q};

endmodule

// ===== rtl/l4hpf_checker.sv =====
// ----------------------------------------------------------------------------
// l4hpf_checker
// Port-level checks of the header filter, bound to the top level.
// ----------------------------------------------------------------------------
module l4hpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);
  import l4hpf_pkg::*;

  logic [2:0] verdict;
  logic [3:0] kind;

  assign verdict = m_tdata[2:0];
  assign kind    = m_tdata[60:57];

  // no word comes out right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // offset and length only travel with a forward verdict
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (verdict != VERDICT_FORWARD) |-> (m_tdata[56:35] == 22'd0))
    else $error("payload fields set without forward verdict");

  a_kind_decoded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((kind != KIND_NONE) == (verdict == VERDICT_DECODED)))
    else $error("message kind and decoded verdict disagree");

  // ports only appear for tcp or udp results
  a_ports: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (verdict != VERDICT_FORWARD) && (verdict != VERDICT_DROP)
      |-> (m_tdata[34:3] == 32'd0))
    else $error("ports set for non tcp/udp result");

endmodule

bind l4_header_port_filter l4hpf_checker u_l4hpf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
